### src/thq_pkg.sv
// thq_pkg: shared types and constants of the terrain height query block
// no dependencies
`default_nettype none
package thq_pkg;

	// magnitude width of the plane numerator inside the divider
	localparam int RW = 56;
	// quotient bits resolved by the divider chain
	localparam int QW = 16;

	localparam logic [1:0] REG_TRIANGLE_COUNT   = 2'd0;
	localparam logic [1:0] REG_STEP_LIMIT       = 2'd1;
	localparam logic [1:0] REG_STRICT_TOLERANCE = 2'd2;
	localparam logic [1:0] REG_LOOSE_TOLERANCE  = 2'd3;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [31:0]        c0;
		logic [31:0]        c1;
		logic [31:0]        c2;
		logic signed [34:0] a;
		logic signed [34:0] b;
		logic signed [34:0] c;
		logic signed [52:0] d;
	} tri_t;

	localparam int TRI_W = $bits(tri_t);

	// flags that travel with one triangle through the divider cells
	typedef struct packed {
		logic vld;
		logic last;
		logic hit;
		logic neg;
		logic ovf;
	} div_tag_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_A,
		ST_LOAD_B,
		ST_LOAD_C,
		ST_LOAD_D,
		ST_ISSUE,
		ST_DRAIN,
		ST_RESULT
	} state_t;

endpackage
`default_nettype wire

### src/thq_ram.sv
// thq_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none
module thq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### src/thq_div_cell.sv
// thq_div_cell: one restoring divider cell, resolves a single quotient bit
// depends on thq_pkg
`default_nettype none
module thq_div_cell
	import thq_pkg::*;
#(
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire div_tag_t      tag_i,
	input  wire logic [RW-1:0] rem_i,
	input  wire logic [34:0]   div_i,
	input  wire logic [QW-1:0] quo_i,
	output div_tag_t           tag_o,
	output logic      [RW-1:0] rem_o,
	output logic      [34:0]   div_o,
	output logic      [QW-1:0] quo_o
);
	logic [RW-1:0] shifted;
	logic          ge;
	logic [QW-1:0] quo_next;

	always_comb begin
		shifted = RW'(div_i) << BIT;
		ge = rem_i >= shifted;
		quo_next = quo_i;
		quo_next[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_o <= '0;
		end else begin
			tag_o <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_o <= ge ? rem_i - shifted : rem_i;
		div_o <= div_i;
		quo_o <= quo_next;
	end
endmodule
`default_nettype wire

### src/terrain_height_query.sv
// terrain_height_query: triangle table with plane height lookup
// depends on thq_pkg, thq_ram, thq_div_cell
//
// usage: raise start with the item fields while busy is low; the item is taken
// at that edge. kind 0 loads a triangle into slot (plane setup through states
// LOAD_A to LOAD_D, busy meanwhile); a slot at or above MAX_TRIANGLES is
// dropped. kind 1 runs a query: the triangle table is read one slot per cycle
// and every triangle flows through edge tests, plane evaluation and a row of
// sixteen divider cells, one quotient bit per cell. the result appears on
// found and height with done high for exactly one cycle; the receiver cannot
// stall it, and busy is already low then. configuration: wr_en, wr_index and
// wr_data write one register per cycle; the user must write them only while
// busy is low, as the block itself does not enforce it. reset clears control
// state and loads the register defaults; the triangle table holds nothing
// until loaded, no clearing pass.
`default_nettype none
module terrain_height_query
	import thq_pkg::*;
#(
	parameter int MAX_TRIANGLES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [15:0]        wr_data,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic [7:0]         slot,
	input  wire logic signed [15:0] v0_x,
	input  wire logic signed [15:0] v0_y,
	input  wire logic signed [15:0] v0_z,
	input  wire logic signed [15:0] v1_x,
	input  wire logic signed [15:0] v1_y,
	input  wire logic signed [15:0] v1_z,
	input  wire logic signed [15:0] v2_x,
	input  wire logic signed [15:0] v2_y,
	input  wire logic signed [15:0] v2_z,
	output logic                    done,
	output logic                    found,
	output logic signed [15:0]      height
);
	localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int CW = $clog2(MAX_TRIANGLES + 1);
	localparam int NW = (CW > 9) ? CW : 9;

	state_t state_q, state_d;

	logic [8:0]  triangle_count_q;
	logic [15:0] step_limit_q, strict_tol_q, loose_tol_q;

	logic [7:0]         slot_q;
	logic signed [15:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
	logic [NW-1:0]      cnt_q, n_eff;

	// load path
	logic signed [33:0] m_q [6];
	logic signed [34:0] a_q, b_q, c_q;
	logic signed [50:0] da_q, db_q, dc_q;
	logic signed [16:0] ux, uy, uz, wx, wy, wz;
	tri_t               wr_tri;
	logic               ram_we;

	// query path
	logic [TRI_W-1:0]   rd_word;
	tri_t               rt;
	logic               vld_s1, last_s1;
	logic               issue;
	logic signed [33:0] e_s2 [6];
	logic signed [51:0] ap_s2, cp_s2;
	logic signed [52:0] d_s2;
	logic signed [34:0] b_s2, b_s3;
	logic               vld_s2, last_s2, vld_s3, last_s3, inside_s3;
	logic signed [53:0] num_s3;
	logic signed [16:0] ex [3], ez [3], sxd [3], szd [3], pxd [3], pzd [3];
	logic signed [34:0] side [3];
	logic               any_neg, any_pos;
	logic [53:0]        absnum;
	logic [34:0]        absb;

	div_tag_t      ch_tag [QW+1];
	logic [RW-1:0] ch_rem [QW+1];
	logic [34:0]   ch_div [QW+1];
	logic [QW-1:0] ch_quo [QW+1];

	logic signed [15:0] h_c, h_s;
	logic signed [16:0] diff_c;
	logic [16:0]        dist_c, dist_s;
	logic               vld_h, last_h, hit_h;

	logic [1:0]         hits_q;
	logic signed [15:0] first_h_q, strict_h_q, loose_h_q;
	logic [16:0]        first_dist_q;
	logic               strict_ok_q, loose_ok_q;
	logic               res_found;
	logic signed [15:0] res_h;

	assign busy = (state_q != ST_IDLE);
	assign n_eff = (NW'(triangle_count_q) > NW'(MAX_TRIANGLES)) ? NW'(MAX_TRIANGLES)
		: NW'(triangle_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			triangle_count_q <= 9'd0;
			step_limit_q <= 16'd16;
			strict_tol_q <= 16'd3;
			loose_tol_q <= 16'd13;
		end else if (wr_en) begin
			case (wr_index)
				REG_TRIANGLE_COUNT:   triangle_count_q <= wr_data[8:0];
				REG_STEP_LIMIT:       step_limit_q <= wr_data;
				REG_STRICT_TOLERANCE: strict_tol_q <= wr_data;
				REG_LOOSE_TOLERANCE:  loose_tol_q <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (kind == KIND_LOAD) state_d = ST_LOAD_A;
					else if (n_eff == '0) state_d = ST_RESULT;
					else state_d = ST_ISSUE;
				end
			end
			ST_LOAD_A: state_d = ST_LOAD_B;
			ST_LOAD_B: state_d = ST_LOAD_C;
			ST_LOAD_C: state_d = ST_LOAD_D;
			ST_LOAD_D: state_d = ST_IDLE;
			ST_ISSUE: begin
				issue = 1'b1;
				if (cnt_q == n_eff - NW'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (vld_h && last_h) state_d = ST_RESULT;
			end
			ST_RESULT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) cnt_q <= '0;
			else if (issue) cnt_q <= cnt_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			slot_q <= slot;
			x0_q <= v0_x; y0_q <= v0_y; z0_q <= v0_z;
			x1_q <= v1_x; y1_q <= v1_y; z1_q <= v1_z;
			x2_q <= v2_x; y2_q <= v2_y; z2_q <= v2_z;
		end
	end

	// plane setup for a load
	always_comb begin
		ux = 17'(x1_q) - 17'(x0_q);
		uy = 17'(y1_q) - 17'(y0_q);
		uz = 17'(z1_q) - 17'(z0_q);
		wx = 17'(x2_q) - 17'(x0_q);
		wy = 17'(y2_q) - 17'(y0_q);
		wz = 17'(z2_q) - 17'(z0_q);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD_A) begin
			m_q[0] <= uy * wz;
			m_q[1] <= uz * wy;
			m_q[2] <= uz * wx;
			m_q[3] <= ux * wz;
			m_q[4] <= ux * wy;
			m_q[5] <= uy * wx;
		end
		if (state_q == ST_LOAD_B) begin
			a_q <= 35'(m_q[0]) - 35'(m_q[1]);
			b_q <= 35'(m_q[2]) - 35'(m_q[3]);
			c_q <= 35'(m_q[4]) - 35'(m_q[5]);
		end
		if (state_q == ST_LOAD_C) begin
			da_q <= a_q * x0_q;
			db_q <= b_q * y0_q;
			dc_q <= c_q * z0_q;
		end
	end

	always_comb begin
		wr_tri.c0 = {z0_q, x0_q};
		wr_tri.c1 = {z1_q, x1_q};
		wr_tri.c2 = {z2_q, x2_q};
		wr_tri.a = a_q;
		wr_tri.b = b_q;
		wr_tri.c = c_q;
		wr_tri.d = -(53'(da_q) + 53'(db_q) + 53'(dc_q));
		ram_we = (state_q == ST_LOAD_D) && (32'(slot_q) < MAX_TRIANGLES);
	end

	thq_ram #(
		.WIDTH(TRI_W),
		.DEPTH(MAX_TRIANGLES),
		.AW(AW)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(AW'(slot_q)),
		.wdata(wr_tri),
		.raddr(AW'(cnt_q)),
		.rdata(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// edge tests and plane terms
	always_comb begin
		rt = tri_t'(rd_word);
		ex[0] = 17'($signed(rt.c1[15:0])); ez[0] = 17'($signed(rt.c1[31:16]));
		ex[1] = 17'($signed(rt.c2[15:0])); ez[1] = 17'($signed(rt.c2[31:16]));
		ex[2] = 17'($signed(rt.c0[15:0])); ez[2] = 17'($signed(rt.c0[31:16]));
		sxd[0] = 17'($signed(rt.c0[15:0])) - ex[0];
		szd[0] = 17'($signed(rt.c0[31:16])) - ez[0];
		sxd[1] = 17'($signed(rt.c1[15:0])) - ex[1];
		szd[1] = 17'($signed(rt.c1[31:16])) - ez[1];
		sxd[2] = 17'($signed(rt.c2[15:0])) - ex[2];
		szd[2] = 17'($signed(rt.c2[31:16])) - ez[2];
		for (int k = 0; k < 3; k++) begin
			pxd[k] = 17'(x0_q) - ex[k];
			pzd[k] = 17'(z0_q) - ez[k];
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= (cnt_q == n_eff - NW'(1));
		for (int k = 0; k < 3; k++) begin
			e_s2[2*k] <= pxd[k] * szd[k];
			e_s2[2*k+1] <= sxd[k] * pzd[k];
		end
		ap_s2 <= rt.a * x0_q;
		cp_s2 <= rt.c * z0_q;
		d_s2 <= rt.d;
		b_s2 <= rt.b;
		last_s2 <= last_s1;
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			side[k] = 35'(e_s2[2*k]) - 35'(e_s2[2*k+1]);
		end
		any_neg = side[0] < 0 || side[1] < 0 || side[2] < 0;
		any_pos = side[0] > 0 || side[1] > 0 || side[2] > 0;
	end

	always_ff @(posedge clk) begin
		num_s3 <= -(54'(ap_s2) + 54'(cp_s2) + 54'(d_s2));
		b_s3 <= b_s2;
		inside_s3 <= !(any_neg && any_pos);
		last_s3 <= last_s2;
	end

	// magnitudes and overflow check feed the cell row
	always_comb begin
		absnum = num_s3[53] ? 54'(-num_s3) : 54'(num_s3);
		absb = b_s3[34] ? 35'(-b_s3) : 35'(b_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_tag[0] <= '0;
		end else begin
			ch_tag[0].vld <= vld_s3;
			ch_tag[0].last <= last_s3;
			ch_tag[0].hit <= inside_s3 && (b_s3 != '0);
			ch_tag[0].neg <= num_s3[53] ^ b_s3[34];
			ch_tag[0].ovf <= RW'(absnum) >= (RW'(absb) << QW);
		end
	end

	always_ff @(posedge clk) begin
		ch_rem[0] <= RW'(absnum);
		ch_div[0] <= absb;
		ch_quo[0] <= '0;
	end

	for (genvar g = 0; g < QW; g++) begin : g_cell
		thq_div_cell #(
			.BIT(QW - 1 - g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tag_i(ch_tag[g]),
			.rem_i(ch_rem[g]),
			.div_i(ch_div[g]),
			.quo_i(ch_quo[g]),
			.tag_o(ch_tag[g+1]),
			.rem_o(ch_rem[g+1]),
			.div_o(ch_div[g+1]),
			.quo_o(ch_quo[g+1])
		);
	end

	// sign, saturation and distance
	always_comb begin
		if (ch_tag[QW].neg) begin
			if (ch_tag[QW].ovf || ch_quo[QW] > 16'h8000) h_c = 16'sh8000;
			else h_c = 16'(-$signed({1'b0, ch_quo[QW]}));
		end else begin
			if (ch_tag[QW].ovf || ch_quo[QW][15]) h_c = 16'sh7fff;
			else h_c = $signed(ch_quo[QW]);
		end
		diff_c = 17'(y0_q) - 17'(h_c);
		dist_c = diff_c[16] ? 17'(-diff_c) : 17'(diff_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_h <= 1'b0;
		end else begin
			vld_h <= ch_tag[QW].vld;
		end
	end

	always_ff @(posedge clk) begin
		last_h <= ch_tag[QW].last;
		hit_h <= ch_tag[QW].hit;
		h_s <= h_c;
		dist_s <= dist_c;
	end

	// hit bookkeeping in slot order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= 2'd0;
			strict_ok_q <= 1'b0;
			loose_ok_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			hits_q <= 2'd0;
			strict_ok_q <= 1'b0;
			loose_ok_q <= 1'b0;
		end else if (vld_h && hit_h) begin
			if (hits_q != 2'd2) hits_q <= hits_q + 2'd1;
			if (dist_s < 17'(strict_tol_q)) strict_ok_q <= 1'b1;
			if (dist_s < 17'(loose_tol_q)) loose_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q != ST_IDLE && vld_h && hit_h) begin
			if (hits_q == 2'd0) begin
				first_h_q <= h_s;
				first_dist_q <= dist_s;
			end
			if (dist_s < 17'(strict_tol_q)) strict_h_q <= h_s;
			if (dist_s < 17'(loose_tol_q) && (!loose_ok_q || h_s > loose_h_q)) begin
				loose_h_q <= h_s;
			end
		end
	end

	always_comb begin
		res_found = 1'b0;
		res_h = '0;
		if (hits_q == 2'd1) begin
			if (first_dist_q < 17'(step_limit_q)) begin
				res_found = 1'b1;
				res_h = first_h_q;
			end
		end else if (hits_q == 2'd2) begin
			if (loose_ok_q) begin
				res_found = 1'b1;
				res_h = loose_h_q;
			end else if (strict_ok_q) begin
				res_found = 1'b1;
				res_h = strict_h_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_RESULT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT) begin
			found <= res_found;
			height <= res_h;
		end
	end
endmodule
`default_nettype wire
